// File: rtl/csl_pkg.sv
// shared constants, types and score helpers for the color spot locator
`default_nettype none

package csl_pkg;

    localparam int CSL_COORD_BITS  = 12;
    localparam int CSL_QUEUE_DEPTH = 4;
    localparam int CSL_FRAME_BITS  = 13;
    localparam int CSL_CHAN_W      = 8;
    localparam int CSL_SUM_W       = 10;
    localparam int CSL_CBEST_W     = 11;
    localparam int CSL_FBEST_W     = 9;
    localparam int CSL_SPOTS       = 4;
    localparam int CSL_EDGE        = 3;

    localparam int CSL_SPOT_BLUE  = 0;
    localparam int CSL_SPOT_GREEN = 1;
    localparam int CSL_SPOT_RED   = 2;
    localparam int CSL_SPOT_WHITE = 3;

    localparam int CSL_CFG_IDX_W = 2;
    localparam logic [CSL_CFG_IDX_W-1:0] CSL_REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CSL_CFG_IDX_W-1:0] CSL_REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CSL_FRAME_BITS-1:0] CSL_WIDTH_RESET  = 13'd640;
    localparam logic [CSL_FRAME_BITS-1:0] CSL_HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic refine;
        logic eof;
        logic in_frame;
    } csl_flags_t;

    // coarse pass: clamped dominance scores and brightness
    // refine pass: blue, green, red and blue plus green
    typedef struct packed {
        logic [CSL_CHAN_W-1:0] s0;
        logic [CSL_CHAN_W-1:0] s1;
        logic [CSL_CHAN_W-1:0] s2;
        logic [CSL_SUM_W-1:0]  s3;
    } csl_scores_t;

    function automatic logic [CSL_CBEST_W-1:0] csl_coarse_score(csl_scores_t s, int k);
        logic [CSL_CBEST_W-1:0] v;
        case (k)
            CSL_SPOT_BLUE:  v = CSL_CBEST_W'(s.s0);
            CSL_SPOT_GREEN: v = CSL_CBEST_W'(s.s1);
            CSL_SPOT_RED:   v = CSL_CBEST_W'(s.s2);
            default:        v = CSL_CBEST_W'(s.s3);
        endcase
        return v;
    endfunction

    function automatic logic [CSL_FBEST_W-1:0] csl_fine_score(csl_scores_t s, int k);
        logic [CSL_FBEST_W-1:0] v;
        case (k)
            CSL_SPOT_BLUE:  v = CSL_FBEST_W'(s.s0);
            CSL_SPOT_GREEN: v = CSL_FBEST_W'(s.s1);
            CSL_SPOT_RED:   v = CSL_FBEST_W'(s.s2);
            default:        v = s.s3[CSL_FBEST_W-1:0];
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/csl_front.sv
// front stage: accepts pixels, range checks them and forms the scores
`default_nettype none

module csl_front
    import csl_pkg::*;
#(
    parameter int COORD_BITS = CSL_COORD_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [CSL_FRAME_BITS-1:0] frame_width,
    input  wire logic [CSL_FRAME_BITS-1:0] frame_height,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      kind,
    input  wire logic [COORD_BITS-1:0]     pixel_row,
    input  wire logic [COORD_BITS-1:0]     pixel_col,
    input  wire logic [CSL_CHAN_W-1:0]     blue,
    input  wire logic [CSL_CHAN_W-1:0]     green,
    input  wire logic [CSL_CHAN_W-1:0]     red,
    input  wire logic                      end_of_frame,
    output logic                           item_valid,
    input  wire logic                      item_full,
    output csl_flags_t                     item_flags,
    output logic [COORD_BITS-1:0]          item_row,
    output logic [COORD_BITS-1:0]          item_col,
    output csl_scores_t                    item_scores
);

    localparam int CW = ((COORD_BITS > CSL_FRAME_BITS) ? COORD_BITS : CSL_FRAME_BITS) + 1;

    logic        valid_reg;
    logic        valid_next;
    logic        accept;
    csl_flags_t  flags_reg;
    csl_flags_t  flags_next;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] col_reg;
    csl_scores_t scores_reg;
    csl_scores_t scores_next;

    assign in_stall = valid_reg && item_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (!item_full)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_comb
    begin
        logic [CSL_CHAN_W:0]  gr;
        logic [CSL_CHAN_W:0]  br;
        logic [CSL_CHAN_W:0]  bg;
        logic [CSL_SUM_W-1:0] sum;
        logic [CW-1:0]        row_x;
        logic [CW-1:0]        col_x;
        gr    = {1'b0, green} + {1'b0, red};
        br    = {1'b0, blue} + {1'b0, red};
        bg    = {1'b0, blue} + {1'b0, green};
        sum   = CSL_SUM_W'(bg) + CSL_SUM_W'(red);
        row_x = CW'(pixel_row);
        col_x = CW'(pixel_col);

        flags_next.refine   = kind;
        flags_next.eof      = end_of_frame;
        flags_next.in_frame = (row_x >= CW'(CSL_EDGE)) && (col_x >= CW'(CSL_EDGE))
                              && (row_x < CW'(frame_height)) && (col_x < CW'(frame_width));

        if (kind)
        begin
            scores_next.s0 = blue;
            scores_next.s1 = green;
            scores_next.s2 = red;
            scores_next.s3 = CSL_SUM_W'(bg);
        end
        else
        begin
            // negative dominance never beats a best that starts at zero
            scores_next.s0 = ({1'b0, blue} > gr) ? CSL_CHAN_W'({1'b0, blue} - gr) : '0;
            scores_next.s1 = ({1'b0, green} > br) ? CSL_CHAN_W'({1'b0, green} - br) : '0;
            scores_next.s2 = ({1'b0, red} > bg) ? CSL_CHAN_W'({1'b0, red} - bg) : '0;
            scores_next.s3 = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg  <= flags_next;
            row_reg    <= pixel_row;
            col_reg    <= pixel_col;
            scores_reg <= scores_next;
        end
    end

    assign item_valid  = valid_reg;
    assign item_flags  = flags_reg;
    assign item_row    = row_reg;
    assign item_col    = col_reg;
    assign item_scores = scores_reg;

endmodule

`default_nettype wire

// File: rtl/csl_queue.sv
// small fifo between the front and back stages
`default_nettype none

module csl_queue
    import csl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CSL_QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  head_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign push       = push_valid && !full;
    assign rdata      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/csl_back.sv
// back stage: coarse and refine spot tracking and the result register
`default_nettype none

module csl_back
    import csl_pkg::*;
#(
    parameter int COORD_BITS = CSL_COORD_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [CSL_FRAME_BITS-1:0] frame_width,
    input  wire logic [CSL_FRAME_BITS-1:0] frame_height,
    input  wire logic                      item_valid,
    output logic                           item_pop,
    input  wire csl_flags_t                item_flags,
    input  wire logic [COORD_BITS-1:0]     item_row,
    input  wire logic [COORD_BITS-1:0]     item_col,
    input  wire csl_scores_t               item_scores,
    output logic                           res_valid,
    input  wire logic                      res_stall,
    output logic [COORD_BITS-1:0]          res_row [CSL_SPOTS],
    output logic [COORD_BITS-1:0]          res_col [CSL_SPOTS],
    output logic                           res_all_found
);

    localparam int CW = ((COORD_BITS > CSL_FRAME_BITS) ? COORD_BITS : CSL_FRAME_BITS) + 1;

    logic [COORD_BITS-1:0]  coarse_row_reg  [CSL_SPOTS];
    logic [COORD_BITS-1:0]  coarse_row_next [CSL_SPOTS];
    logic [COORD_BITS-1:0]  coarse_col_reg  [CSL_SPOTS];
    logic [COORD_BITS-1:0]  coarse_col_next [CSL_SPOTS];
    logic [CSL_CBEST_W-1:0] coarse_best_reg  [CSL_SPOTS];
    logic [CSL_CBEST_W-1:0] coarse_best_next [CSL_SPOTS];
    logic [COORD_BITS-1:0]  fine_row_reg  [CSL_SPOTS];
    logic [COORD_BITS-1:0]  fine_row_next [CSL_SPOTS];
    logic [COORD_BITS-1:0]  fine_col_reg  [CSL_SPOTS];
    logic [COORD_BITS-1:0]  fine_col_next [CSL_SPOTS];
    logic [CSL_FBEST_W-1:0] fine_best_reg  [CSL_SPOTS];
    logic [CSL_FBEST_W-1:0] fine_best_next [CSL_SPOTS];
    logic [COORD_BITS-1:0]  upd_row [CSL_SPOTS];
    logic [COORD_BITS-1:0]  upd_col [CSL_SPOTS];
    logic [CSL_FBEST_W-1:0] upd_best [CSL_SPOTS];

    logic [COORD_BITS-1:0]  out_row_reg [CSL_SPOTS];
    logic [COORD_BITS-1:0]  out_col_reg [CSL_SPOTS];
    logic                   out_all_reg;
    logic                   out_all_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic makes_result;
    logic slot_free;
    logic load_result;

    assign makes_result = item_flags.refine && item_flags.eof;
    assign slot_free    = !out_valid_reg || !res_stall;
    assign item_pop     = item_valid && (!makes_result || slot_free);
    assign load_result  = item_pop && makes_result;

    always_comb
    begin
        logic [CW-1:0]          cr;
        logic [CW-1:0]          cc;
        logic [CW-1:0]          row_x;
        logic [CW-1:0]          col_x;
        logic [CW-1:0]          edge_x;
        logic                   win_ok;
        logic                   in_win;
        logic [CSL_CBEST_W-1:0] cscore;
        logic [CSL_FBEST_W-1:0] fscore;
        row_x        = CW'(item_row);
        col_x        = CW'(item_col);
        edge_x       = CW'(CSL_EDGE);
        out_all_next = 1'b1;
        for (int k = 0; k < CSL_SPOTS; k++)
        begin
            coarse_row_next[k]  = coarse_row_reg[k];
            coarse_col_next[k]  = coarse_col_reg[k];
            coarse_best_next[k] = coarse_best_reg[k];
            upd_row[k]          = fine_row_reg[k];
            upd_col[k]          = fine_col_reg[k];
            upd_best[k]         = fine_best_reg[k];

            cr     = CW'(coarse_row_reg[k]);
            cc     = CW'(coarse_col_reg[k]);
            cscore = csl_coarse_score(item_scores, k);
            fscore = csl_fine_score(item_scores, k);
            // the whole 6x6 window must sit inside the frame
            win_ok = (cr > edge_x) && (cr + edge_x < CW'(frame_height))
                     && (cc > edge_x) && (cc + edge_x < CW'(frame_width));
            in_win = !((row_x + edge_x < cr) || (row_x >= cr + edge_x)
                       || (col_x + edge_x < cc) || (col_x >= cc + edge_x));

            if (item_pop && !item_flags.refine)
            begin
                if (item_flags.in_frame && (cscore > coarse_best_reg[k]))
                begin
                    coarse_best_next[k] = cscore;
                    coarse_row_next[k]  = item_row;
                    coarse_col_next[k]  = item_col;
                end
            end
            else if (item_pop && item_flags.refine)
            begin
                if (win_ok && in_win && (fscore > fine_best_reg[k]))
                begin
                    upd_best[k] = fscore;
                    upd_row[k]  = item_row;
                    upd_col[k]  = item_col;
                end
            end

            if ((upd_row[k] == '0) || (upd_col[k] == '0))
            begin
                out_all_next = 1'b0;
            end

            if (load_result)
            begin
                coarse_row_next[k]  = '0;
                coarse_col_next[k]  = '0;
                coarse_best_next[k] = '0;
                fine_row_next[k]    = '0;
                fine_col_next[k]    = '0;
                fine_best_next[k]   = '0;
            end
            else
            begin
                fine_row_next[k]  = upd_row[k];
                fine_col_next[k]  = upd_col[k];
                fine_best_next[k] = upd_best[k];
            end
        end
    end

    always_comb
    begin
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k < CSL_SPOTS; k++)
            begin
                coarse_row_reg[k]  <= '0;
                coarse_col_reg[k]  <= '0;
                coarse_best_reg[k] <= '0;
                fine_row_reg[k]    <= '0;
                fine_col_reg[k]    <= '0;
                fine_best_reg[k]   <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < CSL_SPOTS; k++)
            begin
                coarse_row_reg[k]  <= coarse_row_next[k];
                coarse_col_reg[k]  <= coarse_col_next[k];
                coarse_best_reg[k] <= coarse_best_next[k];
                fine_row_reg[k]    <= fine_row_next[k];
                fine_col_reg[k]    <= fine_col_next[k];
                fine_best_reg[k]   <= fine_best_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_all_reg <= out_all_next;
            for (int k = 0; k < CSL_SPOTS; k++)
            begin
                out_row_reg[k] <= upd_row[k];
                out_col_reg[k] <= upd_col[k];
            end
        end
    end

    assign res_valid     = out_valid_reg;
    assign res_all_found = out_all_reg;
    assign res_row       = out_row_reg;
    assign res_col       = out_col_reg;

endmodule

`default_nettype wire

// File: rtl/color_spot_locator.sv
// top level of the color spot locator
//
// Pixels come in on the input channel (in_valid / in_stall), one per
// clock when not stalled, first a coarse pass (kind 0) and then a refine
// pass (kind 1) over the same frame in raster order. The refine pixel
// flagged end_of_frame produces one result on the output channel
// (out_valid / out_stall): four refined spot positions and all_found.
// Every other pixel produces nothing.
// Throughput is one pixel per cycle while in_stall is low; the back stage
// updates all four spots together for each pixel. With an empty queue
// out_valid rises once the input transfer has passed the front register,
// the queue and then the result register. cfg_ready is always high.
// frame_width and frame_height must be written on the cfg channel only
// while the block is idle; the block itself does not enforce this.
// Reset clears all spot state and sets the frame to 640 x 480.
// When the receiver stalls, the result holds; pixels keep flowing until
// the next result needs the output register, then the queue fills and
// in_stall rises.
`default_nettype none

module color_spot_locator
    import csl_pkg::*;
#(
    parameter int COORD_BITS  = CSL_COORD_BITS,
    parameter int QUEUE_DEPTH = CSL_QUEUE_DEPTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      kind,
    input  wire logic [COORD_BITS-1:0]     pixel_row,
    input  wire logic [COORD_BITS-1:0]     pixel_col,
    input  wire logic [CSL_CHAN_W-1:0]     blue,
    input  wire logic [CSL_CHAN_W-1:0]     green,
    input  wire logic [CSL_CHAN_W-1:0]     red,
    input  wire logic                      end_of_frame,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [COORD_BITS-1:0]          blue_spot_row,
    output logic [COORD_BITS-1:0]          blue_spot_col,
    output logic [COORD_BITS-1:0]          green_spot_row,
    output logic [COORD_BITS-1:0]          green_spot_col,
    output logic [COORD_BITS-1:0]          red_spot_row,
    output logic [COORD_BITS-1:0]          red_spot_col,
    output logic [COORD_BITS-1:0]          white_spot_row,
    output logic [COORD_BITS-1:0]          white_spot_col,
    output logic                           all_found,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CSL_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CSL_FRAME_BITS-1:0] cfg_data
);

    localparam int ITEM_W = $bits(csl_flags_t) + 2 * COORD_BITS + $bits(csl_scores_t);

    logic [CSL_FRAME_BITS-1:0] frame_width_reg;
    logic [CSL_FRAME_BITS-1:0] frame_height_reg;

    logic                  front_valid;
    logic                  queue_full;
    csl_flags_t            front_flags;
    logic [COORD_BITS-1:0] front_row;
    logic [COORD_BITS-1:0] front_col;
    csl_scores_t           front_scores;
    logic [ITEM_W-1:0]     queue_wdata;
    logic [ITEM_W-1:0]     queue_rdata;
    logic                  queue_head_valid;
    logic                  queue_pop;

    csl_flags_t            back_flags;
    logic [COORD_BITS-1:0] back_row;
    logic [COORD_BITS-1:0] back_col;
    csl_scores_t           back_scores;
    logic [COORD_BITS-1:0] res_row [CSL_SPOTS];
    logic [COORD_BITS-1:0] res_col [CSL_SPOTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CSL_WIDTH_RESET;
            frame_height_reg <= CSL_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CSL_REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CSL_REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    csl_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .pixel_row    (pixel_row),
        .pixel_col    (pixel_col),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .end_of_frame (end_of_frame),
        .item_valid   (front_valid),
        .item_full    (queue_full),
        .item_flags   (front_flags),
        .item_row     (front_row),
        .item_col     (front_col),
        .item_scores  (front_scores)
    );

    assign queue_wdata = {front_flags, front_row, front_col, front_scores};

    csl_queue #(
        .WIDTH(ITEM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .full       (queue_full),
        .wdata      (queue_wdata),
        .head_valid (queue_head_valid),
        .pop        (queue_pop),
        .rdata      (queue_rdata)
    );

    assign {back_flags, back_row, back_col, back_scores} = queue_rdata;

    csl_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .item_valid    (queue_head_valid),
        .item_pop      (queue_pop),
        .item_flags    (back_flags),
        .item_row      (back_row),
        .item_col      (back_col),
        .item_scores   (back_scores),
        .res_valid     (out_valid),
        .res_stall     (out_stall),
        .res_row       (res_row),
        .res_col       (res_col),
        .res_all_found (all_found)
    );

    assign blue_spot_row  = res_row[CSL_SPOT_BLUE];
    assign blue_spot_col  = res_col[CSL_SPOT_BLUE];
    assign green_spot_row = res_row[CSL_SPOT_GREEN];
    assign green_spot_col = res_col[CSL_SPOT_GREEN];
    assign red_spot_row   = res_row[CSL_SPOT_RED];
    assign red_spot_col   = res_col[CSL_SPOT_RED];
    assign white_spot_row = res_row[CSL_SPOT_WHITE];
    assign white_spot_col = res_col[CSL_SPOT_WHITE];

endmodule

`default_nettype wire
